### design/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int DIV_W     = 64;
  localparam int Q_W       = 32;
  localparam int THR_W     = 16;
  localparam int FRONT_LAT = 7;
  localparam int LANE_LAT  = Q_W + 1;
  localparam int NLANE     = 9;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // adjugate entry k = a[p]*a[q] - a[r]*a[s]
  localparam int unsigned COF_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic             neg;
    logic             huge;
  } div_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] det;
    logic              singular;
  } det_info_t;

endpackage

### design/mi3_if.sv
// Valid/ready channel interfaces for matrix words and inverse words.
`timescale 1ns / 1ps
interface mi3_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22;

  modport source (output valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                  input ready);
  modport sink   (input valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                  output ready);
endinterface

interface mi3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22;
  logic signed [31:0] determinant;
  logic               singular;

  modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, determinant, singular, input ready);
  modport sink   (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, determinant, singular, output ready);
endinterface

### design/mi3_front.sv
// Cofactor, determinant and divide-request pipeline (seven stages).
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [DATA_W-1:0] a [NLANE],
  input  logic [THR_W-1:0]         thr,
  output div_req_t                 req [NLANE],
  output det_info_t                info
);

  localparam int CW    = PROD_W - FRAC_BITS;
  localparam int LOW_W = DATA_W + 33;
  localparam int PW2   = DATA_W + CW;
  localparam int SW    = PW2 + 2;
  localparam int DETW  = SW - FRAC_BITS;
  localparam int DMW   = (DETW > DIV_W + 1) ? DETW : DIV_W + 1;

  logic signed [PROD_W-1:0] prod_a [NLANE];
  logic signed [PROD_W-1:0] prod_b [NLANE];
  logic signed [DATA_W-1:0] row0_1 [3];
  logic signed [DATA_W-1:0] row0_2 [3];
  logic signed [CW-1:0]     cof2 [NLANE];
  logic signed [CW-1:0]     cof3 [NLANE];
  logic signed [CW-1:0]     cof4 [NLANE];
  logic signed [CW-1:0]     cof5 [NLANE];
  logic signed [LOW_W-1:0]  plo [3];
  logic signed [CW-1:0]     phi [3];
  logic signed [PW2-1:0]    prod [3];
  logic signed [DETW-1:0]   det;
  logic                     dneg;
  logic [DETW-1:0]          dmag;
  logic                     cneg [NLANE];
  logic [CW-1:0]            cmag [NLANE];
  logic signed [PROD_W-1:0] diff [NLANE];
  logic signed [SW-1:0]     dsum;
  logic [DMW-1:0]           dmx;
  logic                     hi_zero;

  always_comb begin
    for (int k = 0; k < NLANE; k++) diff[k] = prod_a[k] - prod_b[k];
    dsum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    dmx = DMW'(dmag);
    hi_zero = (dmx[DMW-1:DIV_W] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLANE; k++) begin
        prod_a[k] <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
        prod_b[k] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
        cof2[k]   <= diff[k][PROD_W-1:FRAC_BITS];
        cof3[k]   <= cof2[k];
        cof4[k]   <= cof3[k];
        cof5[k]   <= cof4[k];
        cneg[k]   <= cof5[k][CW-1];
        cmag[k]   <= cof5[k][CW-1] ? CW'(-cof5[k]) : CW'(cof5[k]);
      end
      for (int j = 0; j < 3; j++) begin
        row0_1[j] <= a[j];
        row0_2[j] <= row0_1[j];
        plo[j]    <= LOW_W'(row0_2[j] * $signed({1'b0, cof2[3*j][31:0]}));
        phi[j]    <= CW'(row0_2[j] * $signed(cof2[3*j][CW-1:32]));
        prod[j]   <= PW2'(plo[j]) + (PW2'(phi[j]) <<< 32);
      end
      det  <= dsum[SW-1:FRAC_BITS];
      dneg <= det[DETW-1];
      dmag <= det[DETW-1] ? DETW'(-det) : DETW'(det);
      for (int k = 0; k < NLANE; k++) begin
        req[k].num  <= {cmag[k], {FRAC_BITS{1'b0}}};
        req[k].den  <= dmx[DIV_W-1:0];
        req[k].neg  <= cneg[k] ^ dneg;
        req[k].huge <= !hi_zero;
      end
      info.singular <= hi_zero && (dmx[DIV_W-1:0] <= DIV_W'(thr));
      if (dneg)
        info.det <= (dmx > DMW'(SAT_MIN)) ? SAT_MIN : DATA_W'(-dmx[DATA_W-1:0]);
      else
        info.det <= (dmx > DMW'(SAT_MAX)) ? SAT_MAX : dmx[DATA_W-1:0];
    end
  end

endmodule

### design/mi3_div_lane.sv
// One divide lane: overflow check plus 32-stage restoring divider, saturated.
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  div_req_t          req,
  output logic [DATA_W-1:0] result
);

  logic [DIV_W-1:0] rem  [LANE_LAT];
  logic [Q_W-1:0]   low  [LANE_LAT];
  logic [Q_W-1:0]   quo  [LANE_LAT];
  logic [DIV_W-1:0] den  [LANE_LAT];
  logic             ovf  [LANE_LAT];
  logic             neg  [LANE_LAT];
  logic             huge [LANE_LAT];
  logic             top_ovf;

  assign top_ovf = (DIV_W'(req.num[DIV_W-1:Q_W]) >= req.den);

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf[0]  <= top_ovf;
      rem[0]  <= top_ovf ? '0 : DIV_W'(req.num[DIV_W-1:Q_W]);
      low[0]  <= req.num[Q_W-1:0];
      quo[0]  <= '0;
      den[0]  <= req.den;
      neg[0]  <= req.neg;
      huge[0] <= req.huge;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DIV_W:0] t;
    logic           ge;
    assign t  = {rem[i], low[i][Q_W-1]};
    assign ge = (t >= {1'b0, den[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1]  <= ge ? DIV_W'(t - {1'b0, den[i]}) : t[DIV_W-1:0];
        low[i+1]  <= {low[i][Q_W-2:0], 1'b0};
        quo[i+1]  <= {quo[i][Q_W-2:0], ge};
        den[i+1]  <= den[i];
        ovf[i+1]  <= ovf[i];
        neg[i+1]  <= neg[i];
        huge[i+1] <= huge[i];
      end
    end
  end

  always_comb begin
    if (huge[Q_W] || (!ovf[Q_W] && quo[Q_W] == '0))
      result = '0;
    else if (neg[Q_W])
      result = (ovf[Q_W] || quo[Q_W] > SAT_MIN) ? SAT_MIN : DATA_W'(-quo[Q_W]);
    else
      result = (ovf[Q_W] || quo[Q_W] > SAT_MAX) ? SAT_MAX : quo[Q_W];
  end

  logic unused_tail;
  assign unused_tail = ^{rem[Q_W], low[Q_W], den[Q_W]};

endmodule

### design/matrix_inverse_3x3.sv
// Top level: 3x3 matrix inverse by adjugate, nine divide lanes and output merge.
//
// Usage:
//   mat_in carries one matrix word (nine signed fixed-point entries, row-major)
//   per valid/ready handshake; inv_out carries the nine inverse entries, the
//   saturated determinant and the singular flag per handshake.
//   cfg_we/cfg_data write zero_threshold (reset value 1); write it only idle.
// Timing:
//   Accepted matrices pass through the cofactor and determinant pipeline,
//   the restoring divider (one quotient bit per stage in each of nine
//   lanes) and one output register to inv_out.
//   Throughput is one matrix per cycle while inv_out is not stalled.
// Reset: rst clears all valid flags and sets the threshold to 1; the pipeline
//   is empty.
// Stall: when inv_out is valid and not taken, the whole pipeline holds and
//   mat_in.ready drops until the output word is taken.
`timescale 1ns / 1ps
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  mi3_in_if.sink           mat_in,
  mi3_out_if.source        inv_out,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int TOT_LAT = FRONT_LAT + LANE_LAT;

  logic               adv;
  logic [THR_W-1:0]   thr;
  logic [TOT_LAT-1:0] vld;
  logic signed [DATA_W-1:0] a [NLANE];
  div_req_t           req [NLANE];
  det_info_t          info;
  det_info_t          info_d [LANE_LAT];
  logic [DATA_W-1:0]  lane_q [NLANE];
  logic [DATA_W-1:0]  inv_q [NLANE];

  assign adv = !inv_out.valid || inv_out.ready;
  assign mat_in.ready = adv;

  assign a[0] = mat_in.a_00;
  assign a[1] = mat_in.a_01;
  assign a[2] = mat_in.a_02;
  assign a[3] = mat_in.a_10;
  assign a[4] = mat_in.a_11;
  assign a[5] = mat_in.a_12;
  assign a[6] = mat_in.a_20;
  assign a[7] = mat_in.a_21;
  assign a[8] = mat_in.a_22;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .adv  (adv),
    .a    (a),
    .thr  (thr),
    .req  (req),
    .info (info)
  );

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .req    (req[k]),
      .result (lane_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      inv_out.valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[TOT_LAT-2:0], mat_in.valid};
      inv_out.valid <= vld[TOT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info_d[0] <= info;
      for (int i = 1; i < LANE_LAT; i++) info_d[i] <= info_d[i-1];
    end
  end

  // merge: singular forces all nine inverse entries to zero
  always_comb begin
    for (int k = 0; k < NLANE; k++)
      inv_q[k] = info_d[LANE_LAT-1].singular ? '0 : lane_q[k];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_out.inv_00      <= inv_q[0];
      inv_out.inv_01      <= inv_q[1];
      inv_out.inv_02      <= inv_q[2];
      inv_out.inv_10      <= inv_q[3];
      inv_out.inv_11      <= inv_q[4];
      inv_out.inv_12      <= inv_q[5];
      inv_out.inv_20      <= inv_q[6];
      inv_out.inv_21      <= inv_q[7];
      inv_out.inv_22      <= inv_q[8];
      inv_out.determinant <= info_d[LANE_LAT-1].singular ? '0 : info_d[LANE_LAT-1].det;
      inv_out.singular    <= info_d[LANE_LAT-1].singular;
    end
  end

endmodule

### dv/matrix_inverse_3x3_checker.sv
// Checker for the 3x3 matrix inverse: predicts each inverse word and compares.
`timescale 1ns / 1ps
module matrix_inverse_3x3_checker import mi3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mi3_in_if           mat,
  mi3_out_if          inv,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fails
);

  typedef struct packed {
    logic [8:0][31:0] ent;
    logic [31:0]      det;
    logic             sing;
  } inv_word_t;

  inv_word_t  want_q[$];
  logic [15:0] thr;

  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag);
    if (neg) return (mag > 128'h80000000) ? SAT_MIN : -mag[31:0];
    return (mag > 128'h7FFFFFFF) ? SAT_MAX : mag[31:0];
  endfunction

  function automatic inv_word_t calc_inverse(input logic [8:0][31:0] m,
                                             input logic [15:0] zt);
    logic signed [63:0]  a [9];
    logic [63:0]         cof [9];
    logic [63:0]         d, cmag, q;
    logic signed [127:0] det;
    logic [127:0]        dmag;
    logic                dneg;
    inv_word_t           r;
    r = '0;
    for (int k = 0; k < 9; k++) a[k] = $signed(m[k]);
    for (int k = 0; k < 9; k++) begin
      d = a[COF_IDX[k][0]] * a[COF_IDX[k][1]] - a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
      cof[k] = $signed(d) >>> 16;
    end
    det = $signed(a[0]) * $signed(cof[0]) + $signed(a[1]) * $signed(cof[3])
        + $signed(a[2]) * $signed(cof[6]);
    det = det >>> 16;
    dneg = det[127];
    dmag = dneg ? -det : det;
    if (dmag <= {112'd0, zt}) begin
      r.sing = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      q = '0;
      cmag = cof[k][63] ? -cof[k] : cof[k];
      if (dmag[127:64] == 0) q = (cmag << 16) / dmag[63:0];
      r.ent[k] = (q == 0) ? '0 : clamp32(cof[k][63] ^ dneg, {64'd0, q});
    end
    r.det = clamp32(dneg, dmag);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t: mismatch %s got %h exp %h", $time, what, got, exp);
    fails++;
  endtask

  logic [8:0][31:0] got_ent;
  assign got_ent = {inv.inv_22, inv.inv_21, inv.inv_20, inv.inv_12, inv.inv_11,
                    inv.inv_10, inv.inv_02, inv.inv_01, inv.inv_00};

  assign pending = want_q.size();

  always @(posedge clk) begin
    inv_word_t w;
    if (rst) begin
      thr <= 16'd1;
      fails = 0;
      want_q.delete();
    end else begin
      if (cfg_we) thr <= cfg_data;
      if (mat.valid && mat.ready)
        want_q.push_back(calc_inverse({mat.a_22, mat.a_21, mat.a_20, mat.a_12, mat.a_11,
                                       mat.a_10, mat.a_02, mat.a_01, mat.a_00}, thr));
      if (inv.valid && inv.ready) begin
        if (want_q.size() == 0) begin
          report("unexpected word", got_ent[0], '0);
        end else begin
          w = want_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got_ent[k] !== w.ent[k]) report($sformatf("inv[%0d]", k), got_ent[k], w.ent[k]);
          if (inv.determinant !== w.det) report("determinant", inv.determinant, w.det);
          if (inv.singular !== w.sing)
            report("singular", 32'(inv.singular), 32'(w.sing));
        end
      end
    end
  end

endmodule

### dv/matrix_inverse_3x3_tb.sv
// Testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb import mi3_pkg::*;;

  localparam int ONE = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  int          pending, fails;
  logic        quiet = 1'b0;
  logic        long_hold = 1'b0;

  mi3_in_if  mat_if ();
  mi3_out_if out_if ();

  always #1 clk = ~clk;

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst(rst), .mat_in(mat_if), .inv_out(out_if),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  matrix_inverse_3x3_checker chk (
    .clk(clk), .rst(rst), .mat(mat_if), .inv(out_if), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .pending(pending), .fails(fails)
  );

  initial begin
    mat_if.valid = 1'b0;
    {mat_if.a_00, mat_if.a_01, mat_if.a_02, mat_if.a_10, mat_if.a_11,
     mat_if.a_12, mat_if.a_20, mat_if.a_21, mat_if.a_22} = '0;
    out_if.ready = 1'b0;
  end

  // receiver: short random stalls, one long hold on request
  initial begin
    int   hold;
    logic long_done;
    hold = 0;
    long_done = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold && !long_done) begin
        long_done = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(0, 4);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [8:0][31:0] m);
    mat_if.valid <= 1'b1;
    {mat_if.a_22, mat_if.a_21, mat_if.a_20, mat_if.a_12, mat_if.a_11,
     mat_if.a_10, mat_if.a_02, mat_if.a_01, mat_if.a_00} <= m;
    @(posedge clk);
    while (!mat_if.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      mat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(input logic [15:0] v);
    mat_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(4, 26);
      2: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      3: return $urandom_range(0, 3) - 1;
      default: return $signed($urandom) >>> 12;
    endcase
  endfunction

  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] m;
    for (int k = 0; k < 9; k++) m[k] = rand_entry();
    case ($urandom_range(0, 3))
      0: begin
        for (int k = 0; k < 9; k++) m[k] = $signed(m[k]) >>> 14;
        m[0] += ONE; m[4] += ONE; m[8] += ONE;
      end
      1: m[6 + $urandom_range(0, 2)] = m[$urandom_range(0, 2)];
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [8:0][31:0] diag(input logic [31:0] x, y, z);
    logic [8:0][31:0] m;
    m = '0;
    m[0] = x; m[4] = y; m[8] = z;
    return m;
  endfunction

  initial begin
    logic [8:0][31:0] m;
    logic [15:0] thr_set [5];
    thr_set = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'h0040};
    thr_set[3] = $urandom_range(0, 65535);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(diag(ONE, ONE, ONE));
    send('0);
    send({9{SAT_MAX}});
    send({9{SAT_MIN}});
    send(diag(SAT_MAX, SAT_MAX, SAT_MAX));
    send(diag(SAT_MIN, SAT_MIN, SAT_MIN));
    send(diag(SAT_MIN, SAT_MAX, SAT_MIN));
    send(diag(ONE, ONE, 32'd1));
    send(diag(ONE, ONE, 32'd2));
    send(diag(ONE, ONE, -32'sd2));
    send(diag(ONE, ONE, 32'd0));
    send(diag(2 * ONE, -4 * ONE, ONE / 2));
    send(diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    m = {SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN};
    send(m);
    m = {SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX};
    send(m);
    m = {32'd9 * ONE, 32'd8 * ONE, 32'd7 * ONE, 32'd6 * ONE, 32'd5 * ONE,
         32'd4 * ONE, 32'd3 * ONE, 32'd2 * ONE, ONE};
    send(m);
    m = {-32'sd3 * ONE, 32'd4 * ONE, 32'd1 * ONE, 32'd2 * ONE, -32'sd5 * ONE,
         32'd7 * ONE, 32'd0, 32'd1 * ONE, 32'd3 * ONE};
    send(m);
    for (int k = 0; k < 9; k++) begin
      m = diag(ONE, ONE, ONE);
      m[k] = 32'h5555_AAAA ^ {32{k[0]}};
      send(m);
    end

    for (int p = 0; p < 5; p++) begin
      drain_and_write(thr_set[p]);
      if (p == 4) quiet = 1'b1;
      for (int i = 0; i < 350; i++) begin
        if (p == 1 && i == 40) long_hold = 1'b1;
        send(rand_matrix());
      end
    end
    mat_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) $display("matrix_inverse_3x3_tb: done, clean");
    else $display("matrix_inverse_3x3_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("matrix_inverse_3x3_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
design/mi3_pkg.sv
design/mi3_if.sv
design/mi3_front.sv
design/mi3_div_lane.sv
design/matrix_inverse_3x3.sv
dv/matrix_inverse_3x3_checker.sv
dv/matrix_inverse_3x3_tb.sv
